/* hdl/bcc_pkg.sv */
// Shared types and constants for the button click classifier.
package bcc_pkg;

	localparam int CFG_WIDTH = 16;

	localparam logic [1:0] CFG_DEBOUNCE     = 2'd0;
	localparam logic [1:0] CFG_DOUBLE_CLICK = 2'd1;
	localparam logic [1:0] CFG_LONG_CLICK   = 2'd2;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET     = 16'd50;
	localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_RESET = 16'd300;
	localparam logic [CFG_WIDTH-1:0] LONG_CLICK_RESET   = 16'd1000;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_CLICK  = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;
	localparam logic [1:0] EV_LONG   = 2'd3;

	typedef struct packed {
		logic        raw_level;
		logic [31:0] now_ms;
		logic        clear_request;
	} sample_t;

	typedef struct packed {
		logic [1:0] event_code;
		logic       pressed;
	} result_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] debounce_ms;
		logic [CFG_WIDTH-1:0] double_click_ms;
		logic [CFG_WIDTH-1:0] long_click_ms;
	} cfg_t;

endpackage

/* hdl/bcc_core.sv */
// Debounce and click classification state with its next-state logic.
module bcc_core #(
	parameter int TIME_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  bcc_pkg::sample_t sample,
	input  bcc_pkg::cfg_t    cfg,
	output bcc_pkg::result_t result
);

	logic                 last_raw_q;
	logic                 stable_q;
	logic [TIME_BITS-1:0] last_change_q;
	logic [TIME_BITS-1:0] press_time_q;
	logic [TIME_BITS-1:0] last_click_q;
	logic                 awaiting_q;
	logic [1:0]           event_q;

	logic                 stable_d;
	logic [TIME_BITS-1:0] last_change_d;
	logic [TIME_BITS-1:0] press_time_d;
	logic [TIME_BITS-1:0] last_click_d;
	logic                 awaiting_d;
	logic [1:0]           event_d;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] deb_diff;
	logic [TIME_BITS-1:0] press_diff;
	logic [TIME_BITS-1:0] click_diff;
	logic                 raw_chg;
	logic                 flip;
	logic                 just_armed;

	assign now_t      = TIME_BITS'(sample.now_ms);
	assign raw_chg    = sample.raw_level != last_raw_q;
	assign deb_diff   = raw_chg ? '0 : now_t - last_change_q;
	assign press_diff = now_t - press_time_q;
	assign click_diff = now_t - last_click_q;
	assign flip       = (deb_diff > TIME_BITS'(cfg.debounce_ms)) &&
		(stable_q != sample.raw_level);
	assign last_change_d = raw_chg ? now_t : last_change_q;

	always_comb begin
		stable_d     = stable_q;
		press_time_d = press_time_q;
		last_click_d = last_click_q;
		awaiting_d   = awaiting_q;
		event_d      = sample.clear_request ? bcc_pkg::EV_NONE : event_q;
		just_armed   = 1'b0;
		if (flip) begin
			stable_d = sample.raw_level;
			if (!sample.raw_level) begin
				press_time_d = now_t;
			end else if (press_diff >= TIME_BITS'(cfg.long_click_ms)) begin
				event_d    = bcc_pkg::EV_LONG;
				awaiting_d = 1'b0;
			end else if (awaiting_q &&
					click_diff <= TIME_BITS'(cfg.double_click_ms)) begin
				event_d    = bcc_pkg::EV_DOUBLE;
				awaiting_d = 1'b0;
			end else begin
				awaiting_d   = 1'b1;
				last_click_d = now_t;
				just_armed   = 1'b1;
			end
		end
		// A click armed in this sample is masked by just_armed and cannot time out yet.
		if (awaiting_d && !just_armed &&
				click_diff > TIME_BITS'(cfg.double_click_ms)) begin
			event_d    = bcc_pkg::EV_CLICK;
			awaiting_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b1;
			stable_q      <= 1'b1;
			last_change_q <= '0;
			press_time_q  <= '0;
			last_click_q  <= '0;
			awaiting_q    <= 1'b0;
			event_q       <= bcc_pkg::EV_NONE;
		end else if (step) begin
			last_raw_q    <= sample.raw_level;
			stable_q      <= stable_d;
			last_change_q <= last_change_d;
			press_time_q  <= press_time_d;
			last_click_q  <= last_click_d;
			awaiting_q    <= awaiting_d;
			event_q       <= event_d;
		end
	end

	assign result.event_code = event_d;
	assign result.pressed    = !stable_d;

	a_flip_on_stable: assert property (@(posedge clk) disable iff (!arst_n)
		step && flip |=> stable_q == !result.pressed)
		else $error("stable level and pressed flag disagree after a flip");

	a_clear_no_old: assert property (@(posedge clk) disable iff (!arst_n)
		step && sample.clear_request && !flip && !awaiting_q |->
			result.event_code == bcc_pkg::EV_NONE)
		else $error("clear request did not remove the latched event");

endmodule

/* hdl/button_click_classifier.sv */
// Top level of the button click classifier: handshakes, registers and core.
// A word accepted into the input register is classified into the result register.
// Throughput: one word per cycle while result_ready does not stall the output.
// The next sample may be taken while a finished result still waits to be taken.
// Reset clears both pipeline stages and the classifier state (released, no event),
// and loads the configuration registers with 50, 300 and 1000 ms.
module button_click_classifier #(
	parameter int TIME_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  bcc_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_ready,
	output bcc_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	bcc_pkg::cfg_t    cfg_q;
	logic             valid_s1;
	bcc_pkg::sample_t sample_s1;
	logic             valid_s2;
	bcc_pkg::result_t result_s2;
	bcc_pkg::result_t core_result;
	logic             ready_s2;
	logic             step;

	assign ready_s2     = !valid_s2 || result_ready;
	assign sample_ready = !valid_s1 || ready_s2;
	assign step         = valid_s1 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= bcc_pkg::DEBOUNCE_RESET;
			cfg_q.double_click_ms <= bcc_pkg::DOUBLE_CLICK_RESET;
			cfg_q.long_click_ms   <= bcc_pkg::LONG_CLICK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcc_pkg::CFG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_data;
				bcc_pkg::CFG_DOUBLE_CLICK: cfg_q.double_click_ms <= cfg_data;
				bcc_pkg::CFG_LONG_CLICK:   cfg_q.long_click_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
		if (step) begin
			result_s2 <= core_result;
		end
	end

	bcc_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.result (core_result)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("input stalled while the result register is empty");

	a_step_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> result_valid)
		else $error("a processed word did not reach the result register");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == bcc_pkg::CFG_DEBOUNCE |=>
			cfg_q.debounce_ms == $past(cfg_data))
		else $error("debounce register write was lost");

endmodule
